// ===== hdl/zctd_pkg.sv =====
// Shared types, codes and alphabet tables for the Z-character text decoder.
// No dependencies; every other file in hdl/ imports this package.
package zctd_pkg;

    // Text word layout
    localparam int CODE_W   = 5;
    localparam int CODES    = 3;
    localparam int END_BIT  = 15;
    localparam int RES_MAX  = 4;
    localparam int CNT_W    = 3;

    // Shift / escape mode held between words
    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_SHIFT   = 3'd1,
        MODE_SPECIAL = 3'd2,
        MODE_ABBR1   = 3'd3,
        MODE_ABBR2   = 3'd4,
        MODE_ABBR3   = 3'd5,
        MODE_ESC_HI  = 3'd6,
        MODE_ESC_LO  = 3'd7
    } mode_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_CHAR   = 2'd0,
        KIND_ABBREV = 2'd1,
        KIND_END    = 2'd2
    } kind_t;

    // Special code values
    localparam logic [CODE_W-1:0] CODE_ABBR_LO = 5'd1;
    localparam logic [CODE_W-1:0] CODE_ABBR_HI = 5'd3;
    localparam logic [CODE_W-1:0] CODE_SHIFT   = 5'd4;
    localparam logic [CODE_W-1:0] CODE_SPECIAL = 5'd5;
    localparam logic [CODE_W-1:0] CODE_ESCAPE  = 5'd6;

    // One result request
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  char_code;
        logic [6:0]  abbrev_index;
        logic [16:0] abbrev_entry_address;
        logic        last;
    } result_t;

    localparam logic [7:0] ALPHA0 [32] = '{
        8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h61, 8'h62,
        8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6a,
        8'h6b, 8'h6c, 8'h6d, 8'h6e, 8'h6f, 8'h70, 8'h71, 8'h72,
        8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7a
    };

    localparam logic [7:0] ALPHA1 [32] = '{
        8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h41, 8'h42,
        8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4a,
        8'h4b, 8'h4c, 8'h4d, 8'h4e, 8'h4f, 8'h50, 8'h51, 8'h52,
        8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5a
    };

    localparam logic [7:0] ALPHA2 [32] = '{
        8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0a,
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h2e, 8'h2c, 8'h21, 8'h3f, 8'h5f, 8'h23,
        8'h27, 8'h22, 8'h2f, 8'h5c, 8'h2d, 8'h3a, 8'h28, 8'h29
    };

    // Look up a character in the alphabet of the current shift mode
    function automatic logic [7:0] alpha_char(input mode_t mode,
                                              input logic [CODE_W-1:0] code);
        logic [7:0] ch;
        unique case (mode)
            MODE_NORMAL:  ch = ALPHA0[code];
            MODE_SHIFT:   ch = ALPHA1[code];
            MODE_SPECIAL: ch = ALPHA2[code];
            default:      ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== hdl/zchar_text_decoder_top.sv =====
// Top level of the Z-character text decoder: input register, mode state,
// word decode and result bank. Depends on zctd_pkg, zctd_decode, zctd_outbuf.
//
// Usage:
//   s_valid/s_ready/s_text_word carry one packed text word per request:
//   bit 15 marks end of string, bits 14..10, 9..5, 4..0 are three codes.
//   m_valid/m_ready carry one result per request: m_kind (character,
//   abbreviation reference, end marker), m_char_code, m_abbrev_index,
//   m_abbrev_entry_address and m_last on the final result of a word.
//   cfg_valid/cfg_ready/cfg_abbrev_table_base set the table base address;
//   write it only while no word is in flight.
// Flow: a word is registered in the input register, decoded once the result
//   bank is free, and its results are registered in the result bank and presented.
// Throughput: the result port takes one result per cycle while m_ready is high;
//   a new word is decoded once all results of the word before are taken; a word yields zero to four results.
// Reset: mode returns to normal, escape bits and table base clear, all
//   buffered words and results are dropped.
// Stall: when m_ready is low, results hold; one further word waits in the
//   input register, after which s_ready drops.
module zchar_text_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_abbrev_table_base,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_text_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_char_code,
    output logic [6:0]  m_abbrev_index,
    output logic [16:0] m_abbrev_entry_address,
    output logic        m_last
);
    import zctd_pkg::*;

    logic             in_valid_reg, in_valid_next;
    logic [15:0]      in_word_reg;
    logic [15:0]      base_reg;
    mode_t            mode_reg, mode_next;
    logic [2:0]       esc_reg,  esc_next;
    logic             buf_free;
    logic             dec_fire;
    result_t          dec_slots [RES_MAX];
    logic [CNT_W-1:0] dec_count;
    result_t          out_res;

    // Configuration: always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
        end else if (cfg_valid) begin
            base_reg <= cfg_abbrev_table_base;
        end
    end

    // Input register
    assign dec_fire = in_valid_reg && buf_free;
    assign s_ready  = !in_valid_reg || buf_free;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (dec_fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_text_word;
        end
    end

    // Word decode
    zctd_decode u_decode (
        .word      (in_word_reg),
        .mode      (mode_reg),
        .esc       (esc_reg),
        .base      (base_reg),
        .slots     (dec_slots),
        .count     (dec_count),
        .mode_next (mode_next),
        .esc_next  (esc_next)
    );

    // Mode state: advance on each decoded word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NORMAL;
            esc_reg  <= '0;
        end else if (dec_fire) begin
            mode_reg <= mode_next;
            esc_reg  <= esc_next;
        end
    end

    // Result bank
    zctd_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (dec_fire),
        .wr_slots (dec_slots),
        .wr_count (dec_count),
        .free     (buf_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (out_res)
    );

    assign m_kind                 = out_res.kind;
    assign m_char_code            = out_res.char_code;
    assign m_abbrev_index         = out_res.abbrev_index;
    assign m_abbrev_entry_address = out_res.abbrev_entry_address;
    assign m_last                 = out_res.last;

    // End marker always closes the results of its word
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_END |-> m_last)
        else $error("end marker without last flag");

    // Entry address tracks table base and abbreviation number
    a_abbrev_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_ABBREV |->
            m_abbrev_entry_address == {1'b0, base_reg} + {9'b0, m_abbrev_index, 1'b0})
        else $error("abbreviation entry address mismatch");

    // End of string leaves the decoder in normal mode with no escape bits
    a_end_resets_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        dec_fire && in_word_reg[END_BIT] |=> mode_reg == MODE_NORMAL && esc_reg == 3'd0)
        else $error("mode not cleared after end of string");

    // A word is decoded only when the result bank has drained
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        dec_fire && m_valid |-> m_ready && m_last)
        else $error("pending results overwritten");

endmodule

// ===== hdl/zctd_step.sv =====
// Decode of one 5-bit code against the current mode: next mode, stored
// escape bits and at most one result. Depends on zctd_pkg.
module zctd_step (
    input  zctd_pkg::mode_t                 mode,
    input  logic [2:0]                      esc,
    input  logic [zctd_pkg::CODE_W-1:0]     code,
    input  logic [15:0]                     base,
    output zctd_pkg::mode_t                 mode_out,
    output logic [2:0]                      esc_out,
    output logic                            emit,
    output zctd_pkg::result_t               res
);
    import zctd_pkg::*;

    logic [2:0] bank_off;
    logic [6:0] idx;

    // Abbreviation number: 32 * bank + code
    assign bank_off = mode - MODE_ABBR1;
    assign idx      = {bank_off[1:0], code};

    // Mode transition and result selection
    always_comb begin
        mode_out = mode;
        esc_out  = esc;
        emit     = 1'b0;
        res      = '0;
        unique case (mode)
            MODE_NORMAL, MODE_SHIFT, MODE_SPECIAL: begin
                if (code >= CODE_ABBR_LO && code <= CODE_ABBR_HI) begin
                    mode_out = mode_t'(code[2:0] + (MODE_ABBR1 - CODE_ABBR_LO[2:0]));
                end else if (code == CODE_SHIFT) begin
                    mode_out = MODE_SHIFT;
                end else if (code == CODE_SPECIAL) begin
                    mode_out = MODE_SPECIAL;
                end else if (code == CODE_ESCAPE && mode == MODE_SPECIAL) begin
                    mode_out = MODE_ESC_HI;
                end else begin
                    emit          = 1'b1;
                    res.kind      = KIND_CHAR;
                    res.char_code = alpha_char(mode, code);
                    mode_out      = MODE_NORMAL;
                end
            end
            MODE_ABBR1, MODE_ABBR2, MODE_ABBR3: begin
                emit                     = 1'b1;
                res.kind                 = KIND_ABBREV;
                res.abbrev_index         = idx;
                res.abbrev_entry_address = {1'b0, base} + {9'b0, idx, 1'b0};
                mode_out                 = MODE_NORMAL;
            end
            MODE_ESC_HI: begin
                esc_out  = code[2:0];
                mode_out = MODE_ESC_LO;
            end
            MODE_ESC_LO: begin
                emit          = 1'b1;
                res.kind      = KIND_CHAR;
                res.char_code = {esc, code};
                mode_out      = MODE_NORMAL;
            end
            default: begin
                mode_out = MODE_NORMAL;
            end
        endcase
    end

endmodule

// ===== hdl/zctd_decode.sv =====
// Decode of one text word: three chained code steps, the end marker and
// packing of the results into consecutive slots. Depends on zctd_pkg, zctd_step.
module zctd_decode (
    input  logic [15:0]                     word,
    input  zctd_pkg::mode_t                 mode,
    input  logic [2:0]                      esc,
    input  logic [15:0]                     base,
    output zctd_pkg::result_t               slots [zctd_pkg::RES_MAX],
    output logic [zctd_pkg::CNT_W-1:0]      count,
    output zctd_pkg::mode_t                 mode_next,
    output logic [2:0]                      esc_next
);
    import zctd_pkg::*;

    mode_t             step_mode [CODES+1];
    logic [2:0]        step_esc  [CODES+1];
    logic [RES_MAX-1:0] emit;
    result_t           item [RES_MAX];
    logic              end_flag;

    assign end_flag     = word[END_BIT];
    assign step_mode[0] = mode;
    assign step_esc[0]  = esc;

    // Chain the three codes, high to low
    for (genvar g = 0; g < CODES; g++) begin : g_step
        zctd_step u_step (
            .mode     (step_mode[g]),
            .esc      (step_esc[g]),
            .code     (word[CODE_W*(CODES-g)-1 -: CODE_W]),
            .base     (base),
            .mode_out (step_mode[g+1]),
            .esc_out  (step_esc[g+1]),
            .emit     (emit[g]),
            .res      (item[g])
        );
    end

    // End-of-string marker
    assign item[RES_MAX-1] = result_t'{kind: KIND_END, default: '0};
    assign emit[RES_MAX-1] = end_flag;

    // End of string drops any unfinished shift, abbreviation or escape
    assign mode_next = end_flag ? MODE_NORMAL : step_mode[CODES];
    assign esc_next  = end_flag ? 3'd0 : step_esc[CODES];

    // Pack emitted results into consecutive slots, flag the final one
    always_comb begin
        logic [CNT_W-1:0] n;
        n = '0;
        for (int k = 0; k < RES_MAX; k++) begin
            slots[k] = '0;
        end
        for (int i = 0; i < RES_MAX; i++) begin
            if (emit[i]) begin
                slots[n[1:0]] = item[i];
                n = n + 1'b1;
            end
        end
        if (n != '0) begin
            slots[2'(n - 1'b1)].last = 1'b1;
        end
        count = n;
    end

endmodule

// ===== hdl/zctd_outbuf.sv =====
// Result register bank: holds the results of one word and hands them out one
// request per cycle while m_ready is high. Depends on zctd_pkg.
module zctd_outbuf (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            wr_en,
    input  zctd_pkg::result_t               wr_slots [zctd_pkg::RES_MAX],
    input  logic [zctd_pkg::CNT_W-1:0]      wr_count,
    output logic                            free,
    output logic                            m_valid,
    input  logic                            m_ready,
    output zctd_pkg::result_t               m_res
);
    import zctd_pkg::*;

    result_t          slot_reg [RES_MAX];
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] rd_reg,  rd_next;
    logic             pop;

    assign m_valid = (rd_reg != cnt_reg);
    assign pop     = m_valid && m_ready;
    assign m_res   = slot_reg[rd_reg[1:0]];

    // Free for the next word once the last pending result leaves
    assign free = !m_valid || (pop && (rd_reg + 1'b1 == cnt_reg));

    // Advance read pointer, reload on a new word
    always_comb begin
        cnt_next = cnt_reg;
        rd_next  = rd_reg;
        if (wr_en) begin
            cnt_next = wr_count;
            rd_next  = '0;
        end else if (pop) begin
            rd_next = rd_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rd_reg  <= '0;
        end else begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
        end
    end

    // Capture result payload
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_reg <= wr_slots;
        end
    end

endmodule

// ===== bench/zchar_text_decoder_checker.sv =====
// Result checker for zchar_text_decoder_top: watches the config, word and result channels,
// predicts the decoded symbol stream and compares it field by field. Depends on zctd_pkg.
`timescale 1ns / 100ps

module zchar_text_decoder_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_abbrev_table_base,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [15:0] s_text_word,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_kind,
    input  logic [7:0]  m_char_code,
    input  logic [6:0]  m_abbrev_index,
    input  logic [16:0] m_abbrev_entry_address,
    input  logic        m_last,
    input  logic        run_done,
    output int          mismatch_count,
    output int          symbols_pending
);
    import zctd_pkg::*;

    // Alphabet 2 from code 6 upward
    localparam logic [7:0] PUNCT_TAB [26] = '{
        8'h00, 8'h0a, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h2e, 8'h2c, 8'h21, 8'h3f, 8'h5f, 8'h23, 8'h27, 8'h22,
        8'h2f, 8'h5c, 8'h2d, 8'h3a, 8'h28, 8'h29
    };

    result_t     expected_symbols [$];
    mode_t       shift_mode;
    logic [2:0]  escape_bits;
    logic [15:0] table_base;
    logic        leftovers_checked;

    assign symbols_pending = expected_symbols.size();

    initial mismatch_count = 0;

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic logic [7:0] alphabet_char(input mode_t amode, input logic [4:0] code);
        if (code == 5'd0) begin
            return 8'h20;
        end
        if (code < 5'd6) begin
            return 8'h00;
        end
        case (amode)
            MODE_NORMAL:  return 8'h5b + {3'b000, code};
            MODE_SHIFT:   return 8'h3b + {3'b000, code};
            MODE_SPECIAL: return PUNCT_TAB[code - 5'd6];
            default:      return 8'h00;
        endcase
    endfunction

    function automatic result_t make_symbol(input kind_t kind, input logic [7:0] ch,
                                            input logic [6:0] idx, input logic [16:0] addr);
        result_t sym;
        sym.kind                 = kind;
        sym.char_code            = ch;
        sym.abbrev_index         = idx;
        sym.abbrev_entry_address = addr;
        sym.last                 = 1'b0;
        return sym;
    endfunction

    // Decode one text word into its symbols and advance the shift state
    task automatic decode_text_word(input logic [15:0] word);
        result_t    batch [RES_MAX];
        int         n;
        logic [4:0] code;
        logic [6:0] idx;
        mode_t      cur;
        n = 0;
        for (int j = 0; j < CODES; j++) begin
            code = word[(14 - 5 * j) -: 5];
            cur  = shift_mode;
            if (cur == MODE_NORMAL || cur == MODE_SHIFT || cur == MODE_SPECIAL) begin
                if (code >= CODE_ABBR_LO && code <= CODE_ABBR_HI) begin
                    shift_mode = mode_t'(3'(MODE_ABBR1 + code - CODE_ABBR_LO));
                end else if (code == CODE_SHIFT) begin
                    shift_mode = MODE_SHIFT;
                end else if (code == CODE_SPECIAL) begin
                    shift_mode = MODE_SPECIAL;
                end else if (code == CODE_ESCAPE && cur == MODE_SPECIAL) begin
                    shift_mode = MODE_ESC_HI;
                end else begin
                    batch[n] = make_symbol(KIND_CHAR, alphabet_char(cur, code), 7'd0, 17'd0);
                    n++;
                    shift_mode = MODE_NORMAL;
                end
            end else if (cur == MODE_ABBR1 || cur == MODE_ABBR2 || cur == MODE_ABBR3) begin
                idx = {2'(cur - MODE_ABBR1), code};
                batch[n] = make_symbol(KIND_ABBREV, 8'd0, idx,
                                       {1'b0, table_base} + {9'd0, idx, 1'b0});
                n++;
                shift_mode = MODE_NORMAL;
            end else if (cur == MODE_ESC_HI) begin
                escape_bits = code[2:0];
                shift_mode  = MODE_ESC_LO;
            end else begin
                batch[n] = make_symbol(KIND_CHAR, {escape_bits, code}, 7'd0, 17'd0);
                n++;
                shift_mode = MODE_NORMAL;
            end
        end
        // End of string drops any unfinished shift, abbreviation or escape
        if (word[END_BIT]) begin
            batch[n] = make_symbol(KIND_END, 8'd0, 7'd0, 17'd0);
            n++;
            shift_mode  = MODE_NORMAL;
            escape_bits = 3'd0;
        end
        if (n > 0) begin
            batch[n - 1].last = 1'b1;
        end
        for (int k = 0; k < n; k++) begin
            expected_symbols.push_back(batch[k]);
        end
    endtask

    // Compare one accepted result with the oldest expected symbol
    task automatic check_symbol();
        result_t want;
        if (expected_symbols.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected, kind %0d char %02h",
                                      m_kind, m_char_code));
            return;
        end
        want = expected_symbols.pop_front();
        if (m_kind !== want.kind) begin
            report_mismatch($sformatf("kind %0d, expected %0d", m_kind, want.kind));
        end
        if (m_char_code !== want.char_code) begin
            report_mismatch($sformatf("char_code %02h, expected %02h",
                                      m_char_code, want.char_code));
        end
        if (m_abbrev_index !== want.abbrev_index) begin
            report_mismatch($sformatf("abbrev_index %0d, expected %0d",
                                      m_abbrev_index, want.abbrev_index));
        end
        if (m_abbrev_entry_address !== want.abbrev_entry_address) begin
            report_mismatch($sformatf("abbrev_entry_address %05h, expected %05h",
                                      m_abbrev_entry_address, want.abbrev_entry_address));
        end
        if (m_last !== want.last) begin
            report_mismatch($sformatf("last %0b, expected %0b", m_last, want.last));
        end
    endtask

    // Sample every channel at the clock edge: config, then words, then results
    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_symbols.delete();
            shift_mode        = MODE_NORMAL;
            escape_bits       = 3'd0;
            table_base        = 16'd0;
            leftovers_checked = 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                table_base = cfg_abbrev_table_base;
            end
            if (s_valid && s_ready) begin
                decode_text_word(s_text_word);
            end
            if (m_valid && m_ready) begin
                check_symbol();
            end
            if (run_done && !leftovers_checked) begin
                leftovers_checked = 1'b1;
                if (expected_symbols.size() != 0) begin
                    report_mismatch($sformatf("%0d expected results never arrived",
                                              expected_symbols.size()));
                end
            end
        end
    end

endmodule

// ===== bench/zchar_text_decoder_top_tb.sv =====
// Testbench top for zchar_text_decoder_top: clock, reset, word and config stimulus,
// result backpressure and verdict. Depends on zctd_pkg and zchar_text_decoder_checker.
`timescale 1ns / 100ps

module zchar_text_decoder_top_tb;
    import zctd_pkg::*;

    localparam int STALL_LIMIT  = 1000;
    localparam int SETTLE_LIMIT = 8;

    // Directed words: spaces, alphabets, shifts, escapes, abbreviations, end of string
    localparam logic [15:0] DIRECTED_WORDS [25] = '{
        {1'b0, 5'd0, 5'd0, 5'd0},
        {1'b0, 5'd6, 5'd31, CODE_SHIFT},
        {1'b0, 5'd31, CODE_SPECIAL, 5'd0},
        {1'b0, CODE_SPECIAL, 5'd7, CODE_SPECIAL},
        {1'b0, 5'd31, CODE_SHIFT, CODE_SPECIAL},
        {1'b0, 5'd8, CODE_SHIFT, CODE_SHIFT},
        {1'b0, 5'd6, CODE_SPECIAL, CODE_ESCAPE},
        {1'b0, 5'd31, 5'd31, CODE_SPECIAL},
        {1'b0, CODE_ESCAPE, 5'd0, 5'd0},
        {1'b0, CODE_ABBR_LO, 5'd0, 5'd2},
        {1'b0, 5'd31, CODE_ABBR_HI, 5'd31},
        {1'b0, CODE_SHIFT, CODE_ABBR_LO, 5'd6},
        {1'b0, CODE_SPECIAL, CODE_ABBR_HI, 5'd0},
        {1'b0, CODE_SHIFT, CODE_SPECIAL, CODE_SHIFT},
        {1'b0, CODE_SHIFT, CODE_SHIFT, CODE_SPECIAL},
        {1'b1, 5'd6, 5'd7, 5'd8},
        {1'b1, 5'd0, 5'd0, CODE_SHIFT},
        {1'b0, 5'd6, 5'd6, 5'd6},
        {1'b1, 5'd0, 5'd0, 5'd2},
        {1'b1, CODE_SPECIAL, CODE_ESCAPE, 5'd9},
        {1'b0, 5'd7, 5'd0, 5'd0},
        {1'b0, 5'd0, CODE_SPECIAL, CODE_ESCAPE},
        {1'b0, 5'd2, 5'd10, 5'd0},
        {1'b1, CODE_SHIFT, CODE_SPECIAL, CODE_SPECIAL},
        {1'b1, 5'd31, 5'd31, 5'd31}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_abbrev_table_base = 16'd0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_text_word = 16'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [7:0]  m_char_code;
    logic [6:0]  m_abbrev_index;
    logic [16:0] m_abbrev_entry_address;
    logic        m_last;
    logic        run_done = 1'b0;
    int          mismatch_count;
    int          symbols_pending;
    int          sender_idle_pct = 37;
    int          receiver_idle_pct = 61;
    int          stall_cycles = 0;

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    zchar_text_decoder_top u_dut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cfg_valid              (cfg_valid),
        .cfg_ready              (cfg_ready),
        .cfg_abbrev_table_base  (cfg_abbrev_table_base),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_text_word            (s_text_word),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_kind                 (m_kind),
        .m_char_code            (m_char_code),
        .m_abbrev_index         (m_abbrev_index),
        .m_abbrev_entry_address (m_abbrev_entry_address),
        .m_last                 (m_last)
    );

    zchar_text_decoder_checker u_checker (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cfg_valid              (cfg_valid),
        .cfg_ready              (cfg_ready),
        .cfg_abbrev_table_base  (cfg_abbrev_table_base),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_text_word            (s_text_word),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_kind                 (m_kind),
        .m_char_code            (m_char_code),
        .m_abbrev_index         (m_abbrev_index),
        .m_abbrev_entry_address (m_abbrev_entry_address),
        .m_last                 (m_last),
        .run_done               (run_done),
        .mismatch_count         (mismatch_count),
        .symbols_pending        (symbols_pending)
    );

    // Random backpressure on the result channel
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // End the run when no request moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Code mix biased toward letters, shifts and abbreviations
    function automatic logic [4:0] random_code();
        int r;
        r = $urandom_range(99);
        if (r < 45) begin
            return 5'($urandom_range(31, 6));
        end else if (r < 55) begin
            return 5'd0;
        end else if (r < 70) begin
            return ($urandom_range(1) == 0) ? CODE_SHIFT : CODE_SPECIAL;
        end else if (r < 82) begin
            return 5'($urandom_range(3, 1));
        end else if (r < 90) begin
            return CODE_ESCAPE;
        end
        return 5'($urandom_range(31));
    endfunction

    // Mostly well-formed words, some escape openers, some raw noise
    function automatic logic [15:0] random_text_word();
        int   r;
        logic eos;
        r   = $urandom_range(99);
        eos = ($urandom_range(99) < 15);
        if (r < 10) begin
            return {eos, CODE_SPECIAL, CODE_ESCAPE, 5'($urandom_range(31))};
        end else if (r < 18) begin
            return {1'b0, random_code(), CODE_SPECIAL, CODE_ESCAPE};
        end else if (r < 25) begin
            return 16'($urandom);
        end
        return {eos, random_code(), random_code(), random_code()};
    endfunction

    // Offer one word, with a random gap before it, and hold until accepted
    task automatic send_text_word(input logic [15:0] word);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_text_word <= word;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    // Hold the sender until every expected result is out and the pipe is empty
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (symbols_pending != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_LIMIT) @(posedge aclk);
    endtask

    task automatic write_table_base(input logic [15:0] base);
        cfg_valid             <= 1'b1;
        cfg_abbrev_table_base <= base;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_words(input int count);
        for (int i = 0; i < count; i++) begin
            send_text_word(random_text_word());
            if ($urandom_range(29) == 0) begin
                settle();
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words with a zero table base, then the top of the address range
        write_table_base(16'h0000);
        for (int i = 0; i < 25; i++) begin
            send_text_word(DIRECTED_WORDS[i]);
        end
        settle();
        write_table_base(16'hffff);
        send_random_words(35);
        settle();

        // Swap the idle ratios
        sender_idle_pct   = 61;
        receiver_idle_pct = 37;
        write_table_base(16'($urandom));
        send_random_words(35);
        settle();

        // Full rate on both sides
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        write_table_base(16'($urandom));
        send_random_words(35);
        settle();

        run_done <= 1'b1;
        repeat (2) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
